// File: sv/tgmpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold gap merge peak caller package
// Field widths, configuration register indexes and the result entry type.
// ----------------------------------------------------------------------------
package tgmpc_pkg;

  localparam int unsigned PosW   = 31;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgCutoff    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinLength = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxGap    = 2'd2;

  // Output queue depth; pointers wrap naturally, so keep it a power of two.
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  typedef struct packed {
    logic [PosW-1:0] peak_start;
    logic [PosW-1:0] peak_end;
    logic            run_last;
  } peak_entry_t;

endpackage

// File: sv/tgmpc_seg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment channel
// Valid/ready channel carrying one track segment per transaction.
// ----------------------------------------------------------------------------
interface tgmpc_seg_if
  import tgmpc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [PosW-1:0]        seg_end;
  logic signed [ValW-1:0] seg_value;
  logic                   seq_last;

  modport source (output valid, seg_end, seg_value, seq_last, input ready);
  modport sink   (input valid, seg_end, seg_value, seq_last, output ready);
endinterface

// File: sv/tgmpc_peak_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak channel
// Valid/ready channel carrying one reported peak per transaction.
// ----------------------------------------------------------------------------
interface tgmpc_peak_if
  import tgmpc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [PosW-1:0] peak_start;
  logic [PosW-1:0] peak_end;
  logic            run_last;

  modport source (output valid, peak_start, peak_end, run_last, input ready);
  modport sink   (input valid, peak_start, peak_end, run_last, output ready);
endinterface

// File: sv/tgmpc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tgmpc_cfg_if
  import tgmpc_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/threshold_gap_merge_peak_caller.sv
`timescale 1ns / 1ps
// Peaks of an accepted segment enter the output queue and leave on peak_o in order.
// Throughput: one segment per cycle when the four-entry output queue has two free slots;
// a segment yields up to two peaks, drained one per cycle while peak_o is ready.
// Reset: asynchronous active low; clears position, open peak, queue and registers
// (cutoff 0, shortest span 1, max_gap 0).
// ----------------------------------------------------------------------------
// Threshold gap merge peak caller
// Calls peaks at or above a cutoff from run-length segments, merging short gaps.
// ----------------------------------------------------------------------------
module threshold_gap_merge_peak_caller
  import tgmpc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  tgmpc_cfg_if.sink      cfg_i,
  tgmpc_seg_if.sink      seg_i,
  tgmpc_peak_if.source   peak_o
);

  // Configuration
  logic signed [ValW-1:0] cutoff_q;
  logic [PosW-1:0]        span_min_q;
  logic [PosW-1:0]        max_gap_q;

  // Track state
  logic [PosW-1:0] segment_start_q, segment_start_d;
  logic            peak_open_q, peak_open_d;
  logic [PosW-1:0] open_start_q, open_start_d;
  logic [PosW-1:0] open_end_q, open_end_d;

  // Output queue
  peak_entry_t          queue_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]   count_q, count_d;

  logic                 seg_fire, peak_fire;
  logic                 is_piece, merge;
  logic signed [PosW:0] gap, old_len, new_len, max_gap_s, min_len_s;
  logic                 emit_a, emit_b;
  peak_entry_t          entry0, entry1;
  logic [1:0]           n_emit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= '0;
      span_min_q <= PosW'(1);
      max_gap_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgCutoff:    cutoff_q   <= $signed(cfg_i.data);
        CfgMinLength: span_min_q <= cfg_i.data[PosW-1:0];
        CfgMaxGap:    max_gap_q  <= cfg_i.data[PosW-1:0];
        default:      ;
      endcase
    end
  end

  assign seg_i.ready = (count_q <= OutCntW'(OutDepth - 2));
  assign seg_fire    = seg_i.valid && seg_i.ready;
  assign peak_fire   = peak_o.valid && peak_o.ready;

  assign max_gap_s = $signed({1'b0, max_gap_q});
  assign min_len_s = $signed({1'b0, span_min_q});
  assign is_piece  = seg_i.seg_value >= cutoff_q;
  assign gap       = $signed({1'b0, segment_start_q}) - $signed({1'b0, open_end_q});
  assign old_len   = $signed({1'b0, open_end_q}) - $signed({1'b0, open_start_q});
  assign merge     = peak_open_q && (gap <= max_gap_s);

  always_comb begin
    open_start_d = open_start_q;
    open_end_d   = open_end_q;
    peak_open_d  = peak_open_q;
    emit_a       = 1'b0;
    if (is_piece) begin
      emit_a      = peak_open_q && !merge && (old_len >= min_len_s);
      peak_open_d = 1'b1;
      open_end_d  = seg_i.seg_end;
      if (!merge) begin
        open_start_d = segment_start_q;
      end
    end
    new_len = $signed({1'b0, open_end_d}) - $signed({1'b0, open_start_d});
    emit_b  = seg_i.seq_last && peak_open_d && (new_len >= min_len_s);
    if (seg_i.seq_last) begin
      peak_open_d     = 1'b0;
      segment_start_d = '0;
    end else begin
      segment_start_d = seg_i.seg_end;
    end
  end

  always_comb begin
    entry1 = '{peak_start: open_start_d, peak_end: open_end_d, run_last: 1'b1};
    if (emit_a) begin
      entry0 = '{peak_start: open_start_q, peak_end: open_end_q, run_last: !emit_b};
    end else begin
      entry0 = entry1;
    end
    n_emit = seg_fire ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segment_start_q <= '0;
      peak_open_q     <= 1'b0;
      open_start_q    <= '0;
      open_end_q      <= '0;
    end else if (seg_fire) begin
      segment_start_q <= segment_start_d;
      peak_open_q     <= peak_open_d;
      open_start_q    <= open_start_d;
      open_end_q      <= open_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_emit != 2'd0) begin
      queue_q[wr_ptr_q] <= entry0;
    end
    if (n_emit == 2'd2) begin
      queue_q[wr_ptr_q + OutPtrW'(1)] <= entry1;
    end
  end

  assign count_d = count_q + OutCntW'(n_emit) - OutCntW'(peak_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutPtrW'(n_emit);
      if (peak_fire) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      count_q <= count_d;
    end
  end

  assign peak_o.valid      = (count_q != '0);
  assign peak_o.peak_start = queue_q[rd_ptr_q].peak_start;
  assign peak_o.peak_end   = queue_q[rd_ptr_q].peak_end;
  assign peak_o.run_last   = queue_q[rd_ptr_q].run_last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OutCntW'(OutDepth))
    else $error("output queue overflow");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_fire && seg_i.seq_last |=> !peak_open_q && (segment_start_q == '0))
    else $error("last segment left a peak open");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_fire && !seg_i.seq_last |=> segment_start_q == $past(seg_i.seg_end))
    else $error("segment start not advanced");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_fire && !seg_fire |=> count_q == $past(count_q) - OutCntW'(1))
    else $error("queue count did not drain");

endmodule

// File: tb/threshold_gap_merge_peak_caller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold gap merge peak caller testbench
// Drives segment tracks through the block under random back-pressure and
// idle gaps, predicts the peaks from its own copy of the caller state, and
// checks every peak transaction in order.
// ----------------------------------------------------------------------------
module threshold_gap_merge_peak_caller_test;
  import tgmpc_pkg::*;

  localparam logic [PosW-1:0] PosMax = 31'h7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;

  logic clk_i;
  logic rst_ni;

  tgmpc_cfg_if  cfg_if ();
  tgmpc_seg_if  seg_if ();
  tgmpc_peak_if peak_if ();

  threshold_gap_merge_peak_caller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .seg_i  (seg_if),
    .peak_o (peak_if)
  );

  // Caller settings as last written
  logic signed [ValW-1:0] cut_level;
  logic [PosW-1:0]        span_min;
  logic [PosW-1:0]        gap_limit;

  // Track state
  logic [PosW-1:0] next_seg_start;
  logic            peak_is_open;
  logic [PosW-1:0] open_peak_start;
  logic [PosW-1:0] open_peak_end;

  peak_entry_t pending_peaks[$];

  int unsigned fail_count;
  int unsigned idle_pct;
  int unsigned stall_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic bit close_open_peak(output peak_entry_t peak);
    longint span;
    peak = '0;
    if (!peak_is_open) return 1'b0;
    peak_is_open = 1'b0;
    span = longint'(open_peak_end) - longint'(open_peak_start);
    if (span < longint'(span_min)) return 1'b0;
    peak.peak_start = open_peak_start;
    peak.peak_end   = open_peak_end;
    return 1'b1;
  endfunction

  function automatic void predict_peaks(input logic [PosW-1:0] seg_end,
                                        input logic signed [ValW-1:0] seg_value,
                                        input logic seq_last);
    peak_entry_t found[$];
    peak_entry_t peak;
    logic [PosW-1:0] seg_start;
    longint gap;
    seg_start = next_seg_start;
    if (seg_value >= cut_level) begin
      gap = longint'(seg_start) - longint'(open_peak_end);
      if (peak_is_open && gap <= longint'(gap_limit)) begin
        open_peak_end = seg_end;
      end else begin
        if (close_open_peak(peak)) found.insert(found.size(), peak);
        peak_is_open    = 1'b1;
        open_peak_start = seg_start;
        open_peak_end   = seg_end;
      end
    end
    if (seq_last) begin
      if (close_open_peak(peak)) found.insert(found.size(), peak);
      next_seg_start = '0;
    end else begin
      next_seg_start = seg_end;
    end
    if (found.size() > 0) found[found.size()-1].run_last = 1'b1;
    foreach (found[i]) pending_peaks.insert(pending_peaks.size(), found[i]);
  endfunction

  // Peak receiver and checker
  always @(posedge clk_i) begin
    peak_entry_t want;
    if (!rst_ni) begin
      peak_if.ready <= 1'b0;
    end else begin
      peak_if.ready <= ($urandom_range(99) >= stall_pct);
      if (peak_if.valid && peak_if.ready) begin
        if (pending_peaks.size() == 0) begin
          report_mismatch($sformatf("unexpected peak [%0d,%0d) last %0b",
                                    peak_if.peak_start, peak_if.peak_end, peak_if.run_last));
        end else begin
          want = pending_peaks.pop_front();
          if (peak_if.peak_start !== want.peak_start)
            report_mismatch($sformatf("peak_start %0d, expected %0d",
                                      peak_if.peak_start, want.peak_start));
          if (peak_if.peak_end !== want.peak_end)
            report_mismatch($sformatf("peak_end %0d, expected %0d",
                                      peak_if.peak_end, want.peak_end));
          if (peak_if.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %0b, expected %0b",
                                      peak_if.run_last, want.run_last));
        end
      end
    end
  end

  task automatic send_segment(input logic [PosW-1:0] seg_end,
                              input logic signed [ValW-1:0] seg_value,
                              input logic seq_last);
    while ($urandom_range(99) < idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_if.valid     <= 1'b1;
    seg_if.seg_end   <= seg_end;
    seg_if.seg_value <= seg_value;
    seg_if.seq_last  <= seq_last;
    do @(posedge clk_i); while (!seg_if.ready);
    predict_peaks(seg_end, seg_value, seq_last);
  endtask

  // Lets every expected peak drain, then waits on so that segments with no peak also pass.
  task automatic drain_peaks();
    seg_if.valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (index)
      CfgCutoff:    cut_level = data;
      CfgMinLength: span_min  = data[PosW-1:0];
      CfgMaxGap:    gap_limit = data[PosW-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [ValW-1:0] clamp_value(input longint v);
    if (v > longint'(ValMax)) return ValMax;
    if (v < longint'(ValMin)) return ValMin;
    return v[ValW-1:0];
  endfunction

  // Reset settings: first segment above cutoff, merge at zero gap, value at
  // cutoff, gap close with flush in one step, wrapped and zero positions.
  task automatic test_directed_defaults();
    send_segment(31'd5, 32'sd1, 1'b0);
    send_segment(31'd8, -32'sd1, 1'b0);
    send_segment(31'd10, 32'sd0, 1'b0);
    send_segment(31'd12, ValMax, 1'b0);
    send_segment(31'd20, ValMin, 1'b0);
    send_segment(31'd25, 32'sd5, 1'b1);
    send_segment(PosMax, 32'sd1, 1'b0);
    send_segment(31'd3, 32'sd1, 1'b1);
    send_segment(31'd0, 32'sd7, 1'b1);
    drain_peaks();
  endtask

  task automatic test_directed_extremes();
    write_register(CfgCutoff, 32'h8000_0000);
    write_register(CfgMinLength, 32'h0000_0000);
    write_register(CfgMaxGap, 32'hFFFF_FFFF);
    send_segment(31'd4, ValMin, 1'b0);
    send_segment(31'd100, -32'sd5, 1'b0);
    send_segment(31'h7FFF_FFF0, 32'sd3, 1'b1);
    send_segment(31'd2, 32'sd0, 1'b1);
    drain_peaks();
    write_register(CfgCutoff, 32'h7FFF_FFFF);
    write_register(CfgMinLength, 32'h7FFF_FFFF);
    write_register(CfgMaxGap, 32'h0000_0000);
    send_segment(31'd10, ValMax - 32'sd1, 1'b0);
    send_segment(31'd20, ValMax, 1'b0);
    send_segment(PosMax, ValMax, 1'b1);
    send_segment(PosMax, ValMax, 1'b1);
    drain_peaks();
  endtask

  task automatic run_random_tracks(input int unsigned target);
    int unsigned sent;
    int unsigned seq_len;
    int unsigned pick;
    bit          broken;
    logic [PosW-1:0] pos;
    logic signed [ValW-1:0] val;
    sent = 0;
    while (sent < target) begin
      seq_len = $urandom_range(1, 16);
      broken  = ($urandom_range(99) < 5);
      pos     = ($urandom_range(99) < 8) ? PosW'($urandom) : '0;
      for (int i = 0; i < seq_len; i++) begin
        if ($urandom_range(99) < 4)
          pos = PosW'($urandom);
        else
          pos = pos + PosW'($urandom_range(1, ($urandom_range(9) == 0) ? 200 : 6));
        pick = $urandom_range(99);
        if (pick < 45)
          val = clamp_value(longint'(cut_level) + longint'($urandom_range(0, 3)));
        else if (pick < 80)
          val = clamp_value(longint'(cut_level) - longint'($urandom_range(1, 3)));
        else
          val = $urandom;
        send_segment(pos, val, (i == seq_len - 1) && !broken);
        sent++;
      end
    end
    drain_peaks();
  endtask

  task automatic test_random_tracks();
    int unsigned pct_table[4][2];
    pct_table = '{'{0, 0}, '{49, 0}, '{0, 49}, '{33, 33}};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = pct_table[p][0];
      stall_pct = pct_table[p][1];
      for (int s = 0; s < 2; s++) begin
        if ($urandom_range(3) == 0)
          write_register(CfgCutoff, $urandom);
        else
          write_register(CfgCutoff, CfgDataW'($urandom_range(0, 1 << 18) - (1 << 17)));
        write_register(CfgMinLength, $urandom_range(1, 12));
        write_register(CfgMaxGap, $urandom_range(0, 16));
        run_random_tracks(143);
      end
    end
  endtask

  initial begin
    fail_count      = 0;
    idle_pct        = 0;
    stall_pct       = 0;
    cut_level       = '0;
    span_min        = 31'd1;
    gap_limit       = '0;
    next_seg_start  = '0;
    peak_is_open    = 1'b0;
    open_peak_start = '0;
    open_peak_end   = '0;
    rst_ni           = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    seg_if.valid     = 1'b0;
    seg_if.seg_end   = '0;
    seg_if.seg_value = '0;
    seg_if.seq_last  = 1'b0;
    peak_if.ready    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_directed_extremes();
    test_random_tracks();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
